// ----- hw/rtl/assert_macros.svh -----
// assertion macros for the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold in the cycle after the condition
`define ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

// property must hold in the same cycle as the condition
`define ASSERT_SAME(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

`endif

// ----- hw/rtl/hac_pkg.sv -----
// package for the hirose aes-256 compression core
// types, the aes s-box and round helpers; no dependencies
package hac_pkg;

    localparam int unsigned AES_ROUNDS = 14;
    localparam int unsigned STAGES = AES_ROUNDS + 1;

    localparam logic [7:0] CFG_CONST_HIGH = 8'd0;
    localparam logic [7:0] CFG_CONST_LOW = 8'd1;

    typedef logic [127:0] block_t;
    typedef logic [255:0] key_t;

    function automatic logic [7:0] sbox(input logic [7:0] a);
        logic [7:0] r;
        case (a)
            8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
            8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
            8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
            8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
            8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
            8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
            8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
            8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
            8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
            8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
            8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
            8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
            8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
            8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
            8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
            8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
            8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
            8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
            8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
            8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
            8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
            8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
            8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
            8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
            8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
            8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
            8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
            8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
            8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
            8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
            8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
            8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
            8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
            8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
            8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
            8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
            8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
            8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
            8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
            8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
            8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
            8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
            8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
            8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
            8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
            8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
            8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
            8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
            8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
            8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
            8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
            8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
            8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
            8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
            8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
            8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
            8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
            8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
            8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
            8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
            8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
            8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
            8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
            8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; 8'hff: r=8'h16;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    endfunction

    // byte i of a block sits at bits 127-8i down to 120-8i
    function automatic logic [7:0] byte_at(input block_t b, input int unsigned i);
        return b[127 - 8 * i -: 8];
    endfunction

    // one aes round: subbytes, shiftrows, optional mixcolumns, addroundkey
    function automatic block_t aes_round(input block_t s, input block_t rk, input logic mix);
        logic [7:0] t [16];
        logic [7:0] a0, a1, a2, a3, al;
        block_t o;
        for (int c = 0; c < 4; c++)
            for (int i = 0; i < 4; i++)
                t[i + 4 * c] = sbox(byte_at(s, i + 4 * ((c + i) % 4)));
        if (mix)
        begin
            for (int c = 0; c < 4; c++)
            begin
                a0 = t[4 * c]; a1 = t[4 * c + 1]; a2 = t[4 * c + 2]; a3 = t[4 * c + 3];
                al = a0 ^ a1 ^ a2 ^ a3;
                t[4 * c] = a0 ^ al ^ xtime(a0 ^ a1);
                t[4 * c + 1] = a1 ^ al ^ xtime(a1 ^ a2);
                t[4 * c + 2] = a2 ^ al ^ xtime(a2 ^ a3);
                t[4 * c + 3] = a3 ^ al ^ xtime(a3 ^ a0);
            end
        end
        for (int i = 0; i < 16; i++)
            o[127 - 8 * i -: 8] = t[i];
        return o ^ rk;
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
    endfunction

    // advance the 256-bit key window by one 128-bit round key
    // odd step (rot+rcon) when rot is set, even step (subword only) otherwise
    function automatic key_t key_step(input key_t k, input logic rot, input logic [7:0] rc);
        logic [31:0] w [8];
        logic [31:0] t, n0, n1, n2, n3;
        for (int i = 0; i < 8; i++)
            w[i] = k[255 - 32 * i -: 32];
        if (rot)
            t = sub_word({w[7][23:0], w[7][31:24]}) ^ {rc, 24'h0};
        else
            t = sub_word(w[7]);
        n0 = w[0] ^ t;
        n1 = w[1] ^ n0;
        n2 = w[2] ^ n1;
        n3 = w[3] ^ n2;
        return {k[127:0], n0, n1, n2, n3};
    endfunction

endpackage

// ----- hw/rtl/hac_round.sv -----
// one pipeline stage: an aes round on both blocks plus the key window step
// depends on hac_pkg
module hac_round #(
    parameter int unsigned RND = 1
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  hac_pkg::block_t in_g,
    input  hac_pkg::block_t in_gc,
    input  hac_pkg::block_t in_sg,
    input  hac_pkg::block_t in_sc,
    input  hac_pkg::key_t   in_key,
    output logic            out_valid,
    output hac_pkg::block_t out_g,
    output hac_pkg::block_t out_gc,
    output hac_pkg::block_t out_sg,
    output hac_pkg::block_t out_sc,
    output hac_pkg::key_t   out_key
);
    import hac_pkg::*;

    // round RND uses key words 4*RND..4*RND+3; window holds words 4*RND-4..4*RND+3 on entry
    // entry window: rk[RND-1..RND] for RND>=1 is {rk(RND), rk(RND+1)} after step
    localparam logic ROT = (RND % 2) == 1;
    localparam logic [7:0] RC = 8'(1 << ((RND - 1) / 2));

    logic   valid_reg;
    block_t g_reg, gc_reg, sg_reg, sc_reg;
    key_t   key_reg;
    key_t   key_next;
    block_t rk;

    // window on entry holds round keys RND-1 and RND; round RND uses the second half
    assign rk = in_key[127:0];
    assign key_next = (RND < AES_ROUNDS) ? key_step(in_key, ROT, RC) : in_key;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            g_reg   <= in_g;
            gc_reg  <= in_gc;
            sg_reg  <= aes_round(in_sg, rk, RND < AES_ROUNDS);
            sc_reg  <= aes_round(in_sc, rk, RND < AES_ROUNDS);
            key_reg <= key_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_g = g_reg;
    assign out_gc = gc_reg;
    assign out_sg = sg_reg;
    assign out_sc = sc_reg;
    assign out_key = key_reg;
endmodule

// ----- hw/rtl/hirose_aes256_compression_core.sv -----
// Fully pipelined Hirose compression over AES-256: one item is taken per cycle while the
// pipeline advances, and each item passes through one input stage with the initial key
// add, then one register stage per AES round, both encryptions side by side and sharing
// a key schedule that advances with the data, and the output register holding the
// feed-forward xor. The pipeline advances only when its output register is empty or
// being drained, so a stall holds every stage in place. Writes to register indexes
// other than the two constants are ignored.
// Write the constant registers only while the pipeline is empty.
// depends on hac_pkg and hac_round
module hirose_aes256_compression_core (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [383:0] s_tdata,  // g_high, g_low, h_high, h_low, msg_high, msg_low
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [255:0] m_tdata,  // g_next_high, g_next_low, h_next_high, h_next_low
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [7:0]   cfg_index,
    input  logic [63:0]  cfg_data
);
    import hac_pkg::*;

    logic [63:0] const_high_reg, const_low_reg;
    logic        en;
    block_t      g_in, gc_in;
    key_t        key_in;

    logic   v   [STAGES];
    block_t g   [STAGES];
    block_t gc  [STAGES];
    block_t sg  [STAGES];
    block_t sc  [STAGES];
    key_t   key [STAGES];

    logic   valid0_reg;
    block_t g0_reg, gc0_reg, sg0_reg, sc0_reg;
    key_t   key0_reg;

    logic   out_valid_reg;
    block_t out_g_reg, out_h_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            const_high_reg <= '0;
            const_low_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_CONST_HIGH: const_high_reg <= cfg_data;
                CFG_CONST_LOW: const_low_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // pipeline moves when the output register is free or being drained
    assign en = !out_valid_reg || m_tready;
    assign s_tready = en;

    assign g_in = {s_tdata[63:0], s_tdata[127:64]};
    assign gc_in = g_in ^ {const_high_reg, const_low_reg};
    assign key_in = {s_tdata[191:128], s_tdata[255:192], s_tdata[319:256], s_tdata[383:320]};

    // stage 0: initial key add
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid0_reg <= 1'b0;
        else if (en)
            valid0_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            g0_reg <= g_in;
            gc0_reg <= gc_in;
            sg0_reg <= g_in ^ key_in[255:128];
            sc0_reg <= gc_in ^ key_in[255:128];
            key0_reg <= key_in;
        end
    end

    assign v[0] = valid0_reg;
    assign g[0] = g0_reg;
    assign gc[0] = gc0_reg;
    assign sg[0] = sg0_reg;
    assign sc[0] = sc0_reg;
    assign key[0] = key0_reg;

    for (genvar r = 1; r <= AES_ROUNDS; r++)
    begin : g_rnd
        hac_round #(.RND(r)) u_round (
            .clk(clk), .rst_n(rst_n), .en(en),
            .in_valid(v[r - 1]), .in_g(g[r - 1]), .in_gc(gc[r - 1]),
            .in_sg(sg[r - 1]), .in_sc(sc[r - 1]), .in_key(key[r - 1]),
            .out_valid(v[r]), .out_g(g[r]), .out_gc(gc[r]),
            .out_sg(sg[r]), .out_sc(sc[r]), .out_key(key[r])
        );
    end

    // output register: feed-forward xor
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= v[AES_ROUNDS];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_g_reg <= sg[AES_ROUNDS] ^ g[AES_ROUNDS];
            out_h_reg <= sc[AES_ROUNDS] ^ gc[AES_ROUNDS];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata = {out_h_reg[63:0], out_h_reg[127:64], out_g_reg[63:0], out_g_reg[127:64]};
endmodule

// ----- hw/rtl/hac_checker.sv -----
// port-level checker for the compression core, bound to the top level
// depends on assert_macros.svh
`include "assert_macros.svh"
module hac_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [255:0] m_tdata,
    input logic         cfg_ready
);
    `ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "output dropped")
    `ASSERT_SAME(a_ready, !m_tvalid || m_tready, s_tready, "input stalled without cause")
    `ASSERT_SAME(a_stall, m_tvalid && !m_tready, !s_tready, "input taken during stall")
    `ASSERT_SAME(a_cfg, 1'b1, cfg_ready, "config port blocked")
endmodule

bind hirose_aes256_compression_core hac_checker u_hac_checker (.*);

// ----- test/tb_hirose_aes256_compression_core.sv -----
// self-checking testbench for hirose_aes256_compression_core
// predicts each result with its own aes-256 model; depends on hac_pkg and the core rtl
`timescale 1ns / 100ps

module tb_hirose_aes256_compression_core;
    import hac_pkg::*;

    typedef struct packed {
        logic [63:0] msg_low;
        logic [63:0] msg_high;
        logic [63:0] h_low;
        logic [63:0] h_high;
        logic [63:0] g_low;
        logic [63:0] g_high;
    } chain_in_t;

    typedef struct packed {
        logic [63:0] h_next_low;
        logic [63:0] h_next_high;
        logic [63:0] g_next_low;
        logic [63:0] g_next_high;
    } chain_out_t;

    typedef logic [7:0] sched_t [240];

    // index that maps to no register
    localparam logic [7:0] CFG_IDX_UNMAPPED = 8'hff;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [383:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [255:0] m_tdata;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [7:0]   cfg_index;
    logic [63:0]  cfg_data;

    logic [7:0]  sub_tab [256];
    logic [63:0] xor_const_high;
    logic [63:0] xor_const_low;
    chain_out_t  expected_q [$];
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    int unsigned hold_left;
    bit          hold_start;
    int unsigned fail_count;

    hirose_aes256_compression_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] p;
        p = 8'h00;
        for (int i = 0; i < 8; i++)
        begin
            if (b[i])
                p = p ^ a;
            a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
        end
        return p;
    endfunction

    // s-box from the field inverse followed by the affine map
    function automatic void build_sub_tab();
        logic [7:0] inv, b;
        for (int x = 0; x < 256; x++)
        begin
            inv = 8'h00;
            for (int y = 1; y < 256; y++)
                if (gf_mul(x[7:0], y[7:0]) == 8'h01)
                    inv = y[7:0];
            b = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]}
                ^ {inv[4:0], inv[7:5]} ^ {inv[3:0], inv[7:4]} ^ 8'h63;
            sub_tab[x] = b;
        end
    endfunction

    function automatic sched_t expand_key256(input logic [255:0] key);
        sched_t rk;
        logic [7:0] t [4];
        logic [7:0] x;
        logic [7:0] rc;
        for (int i = 0; i < 32; i++)
            rk[i] = key[255 - 8 * i -: 8];
        rc = 8'h01;
        for (int i = 8; i < 60; i++)
        begin
            for (int j = 0; j < 4; j++)
                t[j] = rk[4 * (i - 1) + j];
            if (i % 8 == 0)
            begin
                x = t[0];
                t[0] = sub_tab[t[1]] ^ rc;
                t[1] = sub_tab[t[2]];
                t[2] = sub_tab[t[3]];
                t[3] = sub_tab[x];
                rc = {rc[6:0], 1'b0};
            end
            else if (i % 8 == 4)
            begin
                for (int j = 0; j < 4; j++)
                    t[j] = sub_tab[t[j]];
            end
            for (int j = 0; j < 4; j++)
                rk[4 * i + j] = rk[4 * (i - 8) + j] ^ t[j];
        end
        return rk;
    endfunction

    function automatic logic [127:0] aes_encrypt(input sched_t rk, input logic [127:0] blk);
        logic [7:0] s [16];
        logic [7:0] t [16];
        logic [7:0] a0, a1, a2, a3;
        logic [127:0] res;
        for (int i = 0; i < 16; i++)
            s[i] = blk[127 - 8 * i -: 8] ^ rk[i];
        for (int r = 1; r <= 14; r++)
        begin
            for (int c = 0; c < 4; c++)
                for (int i = 0; i < 4; i++)
                    t[i + 4 * c] = sub_tab[s[i + 4 * ((c + i) % 4)]];
            if (r < 14)
            begin
                for (int c = 0; c < 4; c++)
                begin
                    a0 = t[4 * c]; a1 = t[4 * c + 1]; a2 = t[4 * c + 2]; a3 = t[4 * c + 3];
                    t[4 * c]     = gf_mul(a0, 8'h02) ^ gf_mul(a1, 8'h03) ^ a2 ^ a3;
                    t[4 * c + 1] = a0 ^ gf_mul(a1, 8'h02) ^ gf_mul(a2, 8'h03) ^ a3;
                    t[4 * c + 2] = a0 ^ a1 ^ gf_mul(a2, 8'h02) ^ gf_mul(a3, 8'h03);
                    t[4 * c + 3] = gf_mul(a0, 8'h03) ^ a1 ^ a2 ^ gf_mul(a3, 8'h02);
                end
            end
            for (int i = 0; i < 16; i++)
                s[i] = t[i] ^ rk[16 * r + i];
        end
        for (int i = 0; i < 16; i++)
            res[127 - 8 * i -: 8] = s[i];
        return res;
    endfunction

    function automatic chain_out_t hirose_compress(input chain_in_t it);
        sched_t rk;
        logic [127:0] g, gc, eg, egc;
        chain_out_t o;
        rk = expand_key256({it.h_high, it.h_low, it.msg_high, it.msg_low});
        g = {it.g_high, it.g_low};
        gc = g ^ {xor_const_high, xor_const_low};
        eg = aes_encrypt(rk, g) ^ g;
        egc = aes_encrypt(rk, gc) ^ gc;
        o.g_next_high = eg[127:64];
        o.g_next_low = eg[63:0];
        o.h_next_high = egc[127:64];
        o.h_next_low = egc[63:0];
        return o;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic chain_in_t rand_item();
        chain_in_t it;
        it.g_high = rand64();
        it.g_low = rand64();
        it.h_high = rand64();
        it.h_low = rand64();
        it.msg_high = rand64();
        it.msg_low = rand64();
        return it;
    endfunction

    // receiver side, with a long hold-off on request
    always @(posedge clk)
    begin
        if (hold_start)
        begin
            hold_left = 400;
            hold_start = 0;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        chain_out_t got, exp_res;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata;
            if (expected_q.size() == 0)
            begin
                $error("result transfer with nothing expected: %h", m_tdata);
                fail_count++;
            end
            else
            begin
                exp_res = expected_q.pop_front();
                if (got.g_next_high !== exp_res.g_next_high)
                begin
                    $error("g_next_high expected %h got %h", exp_res.g_next_high,
                           got.g_next_high);
                    fail_count++;
                end
                if (got.g_next_low !== exp_res.g_next_low)
                begin
                    $error("g_next_low expected %h got %h", exp_res.g_next_low,
                           got.g_next_low);
                    fail_count++;
                end
                if (got.h_next_high !== exp_res.h_next_high)
                begin
                    $error("h_next_high expected %h got %h", exp_res.h_next_high,
                           got.h_next_high);
                    fail_count++;
                end
                if (got.h_next_low !== exp_res.h_next_low)
                begin
                    $error("h_next_low expected %h got %h", exp_res.h_next_low,
                           got.h_next_low);
                    fail_count++;
                end
            end
        end
    end

    task automatic send_block(input chain_in_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= it;
        do
            @(posedge clk);
        while (!s_tready);
        expected_q.push_back(hirose_compress(it));
    endtask

    task automatic drain_pipeline();
        s_tvalid <= 1'b0;
        wait (expected_q.size() == 0);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_const(input logic [7:0] idx, input logic [63:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
        if (idx == CFG_CONST_HIGH)
            xor_const_high = val;
        else if (idx == CFG_CONST_LOW)
            xor_const_low = val;
    endtask

    task automatic test_directed();
        chain_in_t it;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        // zero constant after reset, both halves of the result equal
        send_block('0);
        send_block('1);
        it = rand_item();
        send_block(it);
        drain_pipeline();
        write_const(CFG_CONST_HIGH, '1);
        write_const(CFG_CONST_LOW, '1);
        // write to an unmapped index leaves both constants alone
        write_const(CFG_IDX_UNMAPPED, '0);
        send_block('0);
        send_block('1);
        for (int i = 0; i < 6; i++)
        begin
            it = '0;
            it[64 * i +: 64] = 64'h8000_0000_0000_0001 << (i % 2);
            send_block(it);
        end
        drain_pipeline();
        write_const(CFG_CONST_HIGH, 64'h0000_0000_0000_0001);
        write_const(CFG_CONST_LOW, 64'h8000_0000_0000_0000);
        send_block('0);
        send_block('1);
        for (int i = 0; i < 4; i++)
            send_block(rand_item());
        drain_pipeline();
    endtask

    task automatic test_random_phase(input int unsigned idle, input int unsigned stall,
                                     input int unsigned count);
        write_const(CFG_CONST_HIGH, rand64());
        write_const(CFG_CONST_LOW, rand64());
        send_idle_pct = idle;
        recv_stall_pct = stall;
        for (int i = 0; i < count; i++)
            send_block(rand_item());
        drain_pipeline();
    endtask

    task automatic test_backpressure();
        write_const(CFG_CONST_HIGH, 64'h0);
        write_const(CFG_CONST_LOW, 64'h0);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_start = 1;
        for (int i = 0; i < 100; i++)
            send_block(rand_item());
        drain_pipeline();
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        xor_const_high = '0;
        xor_const_low = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_left = 0;
        hold_start = 0;
        fail_count = 0;
        build_sub_tab();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_phase(0, 0, 300);
        test_random_phase(75, 0, 250);
        test_random_phase(0, 75, 250);
        test_random_phase(22, 22, 300);
        test_backpressure();

        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #20000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
